FILE: rtl/shfd_pkg.sv
package shfd_pkg;

  localparam int MaxPayload   = 1024;
  localparam int RestartEvery = 16;

  localparam int OffW = ($clog2(MaxPayload + 1) > 3) ? $clog2(MaxPayload + 1) : 3;
  localparam int RstW = (RestartEvery > 1) ? $clog2(RestartEvery) : 1;

  localparam logic [7:0]  SyncByteRst     = 8'd165;
  localparam logic [10:0] MaxLengthRst    = 11'd1024;
  localparam logic [15:0] TimeoutTicksRst = 16'd1000;

  typedef enum logic [1:0] {
    CFG_SYNC_BYTE     = 2'd0,
    CFG_MAX_LENGTH    = 2'd1,
    CFG_TIMEOUT_TICKS = 2'd2
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_IGNORED   = 4'd0,
    ST_SYNC      = 4'd1,
    ST_HEADER    = 4'd2,
    ST_PAYLOAD   = 4'd3,
    ST_CKA_OK    = 4'd4,
    ST_GOOD      = 4'd5,
    ST_BAD_SUM   = 4'd6,
    ST_TOO_LONG  = 4'd7,
    ST_TIMEOUT   = 4'd8,
    ST_IDLE_TICK = 4'd9
  } status_t;

  localparam logic REQ_BYTE = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  typedef struct packed {
    logic [7:0]  sync_byte;
    logic [10:0] max_length;
    logic [15:0] timeout_ticks;
  } cfg_t;

  typedef struct packed {
    status_t     status;
    logic [7:0]  payload_byte;
    logic [9:0]  payload_index;
    logic [7:0]  msg_id;
    logic [7:0]  seq_num;
    logic [15:0] frame_length;
    logic        restarted;
    logic        last;
  } res_t;

endpackage

FILE: rtl/shfd_in_if.sv
interface shfd_in_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] data_byte;

  modport source (output valid, req_type, data_byte, input ready);
  modport sink   (input valid, req_type, data_byte, output ready);
endinterface

FILE: rtl/shfd_out_if.sv
interface shfd_out_if
  import shfd_pkg::*;
;
  logic        valid;
  logic        ready;
  status_t     status;
  logic [7:0]  payload_byte;
  logic [9:0]  payload_index;
  logic [7:0]  msg_id;
  logic [7:0]  seq_num;
  logic [15:0] frame_length;
  logic        restarted;
  logic        last;

  modport source (output valid, status, payload_byte, payload_index, msg_id, seq_num,
                  frame_length, restarted, last, input ready);
  modport sink   (input valid, status, payload_byte, payload_index, msg_id, seq_num,
                  frame_length, restarted, last, output ready);
endinterface

FILE: rtl/shfd_cfg.sv
module shfd_cfg
  import shfd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output cfg_t        cfg
);

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sync_byte     <= SyncByteRst;
      cfg_r.max_length    <= MaxLengthRst;
      cfg_r.timeout_ticks <= TimeoutTicksRst;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SYNC_BYTE:     cfg_r.sync_byte     <= cfg_data[7:0];
        CFG_MAX_LENGTH:    cfg_r.max_length    <= cfg_data[10:0];
        CFG_TIMEOUT_TICKS: cfg_r.timeout_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

FILE: rtl/shfd_core.sv
module shfd_core
  import shfd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_t       cfg,
  input  logic       step_en,
  input  logic       req_type,
  input  logic [7:0] data_byte,
  output res_t       res
);

  typedef enum logic [2:0] {
    PH_WAIT    = 3'd0,
    PH_HEADER  = 3'd1,
    PH_PAYLOAD = 3'd2,
    PH_CKA     = 3'd3,
    PH_CKB     = 3'd4
  } phase_t;

  phase_t          phase_r, phase_nxt;
  logic [7:0]      hdr_r [4];
  logic [7:0]      hdr_nxt [4];
  logic [OffW-1:0] off_r, off_nxt;
  logic [RstW-1:0] rcnt_r, rcnt_nxt;
  logic [7:0]      sa_r, sa_nxt, sb_r, sb_nxt;
  logic [15:0]     tcnt_r, tcnt_nxt;
  logic            run_r, run_nxt;

  logic [7:0]      sa_upd, sb_upd;
  logic [15:0]     len_nxt, len_cur;
  logic            drop, load, open;

  assign sa_upd  = sa_r + data_byte;
  assign sb_upd  = sb_r + sa_upd;
  assign len_cur = {hdr_r[3], hdr_r[2]};

  always_comb begin
    phase_nxt = phase_r;
    hdr_nxt   = hdr_r;
    off_nxt   = off_r;
    rcnt_nxt  = rcnt_r;
    sa_nxt    = sa_r;
    sb_nxt    = sb_r;
    tcnt_nxt  = tcnt_r;
    run_nxt   = run_r;
    drop      = 1'b0;
    load      = 1'b0;
    open      = 1'b0;
    len_nxt   = '0;
    res       = '0;
    res.status = ST_IGNORED;

    if (req_type == REQ_TICK) begin
      res.status = ST_IDLE_TICK;
      if (run_r) begin
        if (tcnt_r <= 16'd1) begin
          res.status = ST_TIMEOUT;
          res.last   = 1'b1;
          drop       = 1'b1;
        end else begin
          tcnt_nxt = tcnt_r - 16'd1;
        end
      end
    end else begin
      case (phase_r)
        PH_HEADER: begin
          sa_nxt = sa_upd;
          sb_nxt = sb_upd;
          hdr_nxt[off_r[1:0]] = data_byte;
          off_nxt    = off_r + OffW'(1);
          res.status = ST_HEADER;
          len_nxt    = {hdr_nxt[3], hdr_nxt[2]};
          if (off_r[1:0] == 2'd3) begin
            if (len_nxt > {5'd0, cfg.max_length} || len_nxt > 16'(MaxPayload)) begin
              res.status = ST_TOO_LONG;
              res.last   = 1'b1;
              drop       = 1'b1;
            end else if (len_nxt != 16'd0) begin
              off_nxt   = '0;
              rcnt_nxt  = '0;
              phase_nxt = PH_PAYLOAD;
            end else begin
              phase_nxt = PH_CKA;
            end
          end
        end
        PH_PAYLOAD: begin
          sa_nxt            = sa_upd;
          sb_nxt            = sb_upd;
          res.status        = ST_PAYLOAD;
          res.payload_byte  = data_byte;
          res.payload_index = 10'(off_r);
          off_nxt           = off_r + OffW'(1);
          if (rcnt_r == RstW'(RestartEvery - 1)) begin
            rcnt_nxt = '0;
            load     = 1'b1;
          end else begin
            rcnt_nxt = rcnt_r + RstW'(1);
          end
          if (16'(off_nxt) >= len_cur) phase_nxt = PH_CKA;
        end
        PH_CKA: begin
          if (data_byte == sa_r) begin
            res.status = ST_CKA_OK;
            phase_nxt  = PH_CKB;
          end else begin
            res.status = ST_BAD_SUM;
            res.last   = 1'b1;
            drop       = 1'b1;
            open       = (data_byte == cfg.sync_byte);
            res.restarted = open;
          end
        end
        PH_CKB: begin
          res.last = 1'b1;
          drop     = 1'b1;
          if (data_byte == sb_r) begin
            res.status = ST_GOOD;
          end else begin
            res.status = ST_BAD_SUM;
            open       = (data_byte == cfg.sync_byte);
            res.restarted = open;
          end
        end
        default: begin
          phase_nxt = PH_WAIT;
          if (data_byte == cfg.sync_byte) begin
            res.status = ST_SYNC;
            open       = 1'b1;
          end
        end
      endcase
    end

    if (drop) begin
      phase_nxt = PH_WAIT;
      sa_nxt    = '0;
      sb_nxt    = '0;
      run_nxt   = 1'b0;
      tcnt_nxt  = '0;
    end
    if (open) begin
      phase_nxt = PH_HEADER;
      off_nxt   = '0;
      load      = 1'b1;
    end
    if (load) begin
      tcnt_nxt = cfg.timeout_ticks;
      run_nxt  = 1'b1;
    end

    res.msg_id       = hdr_nxt[0];
    res.seq_num      = hdr_nxt[1];
    res.frame_length = {hdr_nxt[3], hdr_nxt[2]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_WAIT;
      hdr_r   <= '{default: '0};
      off_r   <= '0;
      rcnt_r  <= '0;
      sa_r    <= '0;
      sb_r    <= '0;
      tcnt_r  <= '0;
      run_r   <= 1'b0;
    end else if (step_en) begin
      phase_r <= phase_nxt;
      hdr_r   <= hdr_nxt;
      off_r   <= off_nxt;
      rcnt_r  <= rcnt_nxt;
      sa_r    <= sa_nxt;
      sb_r    <= sb_nxt;
      tcnt_r  <= tcnt_nxt;
      run_r   <= run_nxt;
    end
  end

endmodule

FILE: rtl/sync_header_fletcher_deframer.sv
// Sync/header/Fletcher-8 frame receiver. Each request is one received byte or one
// timer tick and yields exactly one result, which appears in the cycle after it is taken;
// a new request is taken every cycle while the result register is empty or being
// read, so the rate is one request per cycle, set by the combinational state update
// of the frame state machine and its two 8-bit sums. Payload bytes are streamed out
// with their index and are not buffered. Config registers: 0 sync byte, 1 max
// payload length, 2 timeout in ticks; write them only while the block is idle.
module sync_header_fletcher_deframer
  import shfd_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  shfd_in_if.sink      in_req,
  shfd_out_if.source   out_res,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [15:0]  cfg_data
);

  cfg_t cfg;
  res_t res;
  res_t res_r;
  logic out_valid_r;
  logic step_en;

  assign in_req.ready = !out_valid_r || out_res.ready;
  assign step_en      = in_req.valid && in_req.ready;

  shfd_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  shfd_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .step_en   (step_en),
    .req_type  (in_req.req_type),
    .data_byte (in_req.data_byte),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step_en) begin
      out_valid_r <= 1'b1;
    end else if (out_res.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) res_r <= res;
  end

  assign out_res.valid         = out_valid_r;
  assign out_res.status        = res_r.status;
  assign out_res.payload_byte  = res_r.payload_byte;
  assign out_res.payload_index = res_r.payload_index;
  assign out_res.msg_id        = res_r.msg_id;
  assign out_res.seq_num       = res_r.seq_num;
  assign out_res.frame_length  = res_r.frame_length;
  assign out_res.restarted     = res_r.restarted;
  assign out_res.last          = res_r.last;

`ifndef NO_ASSERTIONS
  a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    step_en |=> out_res.valid)
    else $error("accepted request produced no result");

  a_last_ends_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (out_res.valid && out_res.last) |->
      (out_res.status == ST_GOOD || out_res.status == ST_BAD_SUM ||
       out_res.status == ST_TOO_LONG || out_res.status == ST_TIMEOUT))
    else $error("last flag on a result that does not end a frame");

  a_restart_on_bad_sum: assert property (@(posedge clk) disable iff (!rst_n)
    (out_res.valid && out_res.restarted) |-> (out_res.status == ST_BAD_SUM))
    else $error("restart flag without checksum error");

  a_tick_no_payload: assert property (@(posedge clk) disable iff (!rst_n)
    (step_en && in_req.req_type == REQ_TICK) |=>
      (out_res.payload_byte == 8'd0 && out_res.payload_index == 10'd0))
    else $error("tick request produced payload data");
`endif

endmodule

FILE: dv/shfd_frame_checker.sv
module shfd_frame_checker
  import shfd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  shfd_in_if          req,
  shfd_out_if         res,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output int          mismatches,
  output int          backlog,
  output int          n_req,
  output int          n_res,
  output int          n_good,
  output int          n_dropped
);

  typedef enum logic [2:0] {
    PH_WAIT,
    PH_HDR,
    PH_PAY,
    PH_CKA,
    PH_CKB
  } rx_phase_t;

  logic [7:0]  sync_val;
  logic [10:0] max_len;
  logic [15:0] tmo_val;

  rx_phase_t   ph;
  logic [7:0]  hdr [4];
  logic [15:0] offs;
  logic [7:0]  sum_a;
  logic [7:0]  sum_b;
  logic [15:0] ticks_left;
  logic        timer_on;

  res_t        frame_results_q [$];
  int          err_total;
  int          req_total;
  int          res_total;
  int          good_total;
  int          drop_total;

  function automatic logic [15:0] hdr_len();
    return {hdr[3], hdr[2]};
  endfunction

  function automatic void drop_frame();
    ph         = PH_WAIT;
    sum_a      = '0;
    sum_b      = '0;
    timer_on   = 1'b0;
    ticks_left = '0;
  endfunction

  function automatic void open_frame();
    ph         = PH_HDR;
    offs       = '0;
    ticks_left = tmo_val;
    timer_on   = 1'b1;
  endfunction

  function automatic res_t decode_request(logic rt, logic [7:0] d);
    res_t        r;
    logic [15:0] len;
    logic        ok;
    r = '0;
    r.status = ST_IGNORED;
    if (rt == REQ_TICK) begin
      r.status = ST_IDLE_TICK;
      if (timer_on) begin
        if (ticks_left <= 16'd1) begin
          r.status = ST_TIMEOUT;
          r.last   = 1'b1;
          drop_frame();
        end else begin
          ticks_left = ticks_left - 16'd1;
        end
      end
    end else begin
      if (ph == PH_HDR || ph == PH_PAY) begin
        sum_a = sum_a + d;
        sum_b = sum_b + sum_a;
      end
      case (ph)
        PH_HDR: begin
          hdr[offs[1:0]] = d;
          offs = offs + 16'd1;
          r.status = ST_HEADER;
          if (offs >= 16'd4) begin
            len = hdr_len();
            if (len > {5'd0, max_len} || len > MaxPayload) begin
              r.status = ST_TOO_LONG;
              r.last   = 1'b1;
              drop_frame();
            end else if (len != 16'd0) begin
              offs = '0;
              ph   = PH_PAY;
            end else begin
              ph = PH_CKA;
            end
          end
        end
        PH_PAY: begin
          r.status        = ST_PAYLOAD;
          r.payload_byte  = d;
          r.payload_index = offs[9:0];
          offs = offs + 16'd1;
          if (offs % RestartEvery == 0) begin
            ticks_left = tmo_val;
            timer_on   = 1'b1;
          end
          if (offs >= hdr_len()) ph = PH_CKA;
        end
        PH_CKA, PH_CKB: begin
          ok = (ph == PH_CKA) ? (d == sum_a) : (d == sum_b);
          if (ok && ph == PH_CKA) begin
            r.status = ST_CKA_OK;
            ph = PH_CKB;
          end else if (ok) begin
            r.status = ST_GOOD;
            r.last   = 1'b1;
            drop_frame();
          end else begin
            r.status = ST_BAD_SUM;
            r.last   = 1'b1;
            drop_frame();
            // offending byte may itself open the next frame
            if (d == sync_val) begin
              open_frame();
              r.restarted = 1'b1;
            end
          end
        end
        default: begin
          ph = PH_WAIT;
          if (d == sync_val) begin
            open_frame();
            r.status = ST_SYNC;
          end
        end
      endcase
    end
    r.msg_id       = hdr[0];
    r.seq_num      = hdr[1];
    r.frame_length = hdr_len();
    return r;
  endfunction

  function automatic void cmp(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      err_total++;
    end
  endfunction

  always @(posedge clk) begin : mon
    res_t want;
    if (!rst_n) begin
      sync_val   = SyncByteRst;
      max_len    = MaxLengthRst;
      tmo_val    = TimeoutTicksRst;
      ph         = PH_WAIT;
      hdr        = '{default: 8'd0};
      offs       = '0;
      sum_a      = '0;
      sum_b      = '0;
      ticks_left = '0;
      timer_on   = 1'b0;
      frame_results_q.delete();
      err_total  = 0;
      req_total  = 0;
      res_total  = 0;
      good_total = 0;
      drop_total = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_SYNC_BYTE:     sync_val = cfg_data[7:0];
          CFG_MAX_LENGTH:    max_len  = cfg_data[10:0];
          CFG_TIMEOUT_TICKS: tmo_val  = cfg_data;
          default: ;
        endcase
      end
      if (res.valid === 1'b1 && res.ready === 1'b1) begin
        res_total++;
        if (res.status == ST_GOOD) good_total++;
        if (res.status inside {ST_BAD_SUM, ST_TOO_LONG, ST_TIMEOUT}) drop_total++;
        if (frame_results_q.size() == 0) begin
          $error("result with no request outstanding: status %0d", res.status);
          err_total++;
        end else begin
          want = frame_results_q.pop_front();
          cmp("status", want.status, res.status);
          cmp("payload_byte", want.payload_byte, res.payload_byte);
          cmp("payload_index", want.payload_index, res.payload_index);
          cmp("msg_id", want.msg_id, res.msg_id);
          cmp("seq_num", want.seq_num, res.seq_num);
          cmp("frame_length", want.frame_length, res.frame_length);
          cmp("restarted", want.restarted, res.restarted);
          cmp("last", want.last, res.last);
        end
      end
      if (req.valid === 1'b1 && req.ready === 1'b1) begin
        frame_results_q.push_back(decode_request(req.req_type, req.data_byte));
        req_total++;
      end
    end
    mismatches <= err_total;
    backlog    <= frame_results_q.size();
    n_req      <= req_total;
    n_res      <= res_total;
    n_good     <= good_total;
    n_dropped  <= drop_total;
  end

endmodule

FILE: dv/tb_top.sv
module tb_top;
  import shfd_pkg::*;

  localparam int CycleLimit = 600000;
  localparam int ItemGoal   = 1000;

  typedef enum int {
    FK_GOOD,
    FK_BAD_A,
    FK_BAD_B,
    FK_TOO_LONG,
    FK_CUT,
    FK_NOISE
  } frame_kind_t;

  typedef struct packed {
    logic       rt;
    logic [7:0] d;
  } req_item_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;

  int mismatches, backlog, n_req, n_res, n_good, n_dropped;

  shfd_in_if  req_ch ();
  shfd_out_if res_ch ();

  sync_header_fletcher_deframer DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (req_ch),
    .out_res   (res_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  shfd_frame_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .req        (req_ch),
    .res        (res_ch),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .mismatches (mismatches),
    .backlog    (backlog),
    .n_req      (n_req),
    .n_res      (n_res),
    .n_good     (n_good),
    .n_dropped  (n_dropped)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  req_item_t byte_stream_q [$];
  int        sent;
  int        burst_left;
  int        tick_pct;
  int        frame_items;
  int        n_settings;
  int        rx_holds_wanted;
  int        rx_holds_done;
  int        cycle_cnt;
  int        cur_sync;
  int        cur_max;
  int        cur_tmo;

  task automatic push_raw(logic rt, logic [7:0] d);
    byte_stream_q.push_back(req_item_t'{rt: rt, d: d});
  endtask

  task automatic push_byte(logic [7:0] d);
    if ($urandom_range(0, 99) < tick_pct) begin
      push_raw(REQ_TICK, 8'($urandom));
      frame_items++;
    end
    push_raw(REQ_BYTE, d);
    frame_items++;
  endtask

  function automatic int pick_len(frame_kind_t kind);
    int eff;
    eff = (cur_max < MaxPayload) ? cur_max : MaxPayload;
    if (kind == FK_TOO_LONG)
      return ($urandom_range(0, 1) == 1) ? eff + 1 : $urandom_range(eff + 1, 65535);
    if (eff <= 40 && $urandom_range(0, 3) == 0) return eff;
    return $urandom_range(0, (eff < 40) ? eff : 40);
  endfunction

  function automatic logic [7:0] pick_bad(logic [7:0] good);
    if ($urandom_range(0, 1) == 1 && cur_sync[7:0] != good) return cur_sync[7:0];
    return good ^ 8'($urandom_range(1, 255));
  endfunction

  task automatic build_frame(frame_kind_t kind, int len, bit with_sync);
    logic [7:0] body [$];
    logic [7:0] fa, fb, bad;
    int         n;
    body.push_back(8'($urandom));
    body.push_back(8'($urandom));
    body.push_back(len[7:0]);
    body.push_back(len[15:8]);
    if (kind != FK_TOO_LONG) repeat (len) body.push_back(8'($urandom));
    fa = '0;
    fb = '0;
    foreach (body[i]) begin
      fa = fa + body[i];
      fb = fb + fa;
    end
    n = (kind == FK_CUT) ? $urandom_range(1, body.size()) : body.size();
    if (with_sync) push_byte(cur_sync[7:0]);
    for (int i = 0; i < n; i++) push_byte(body[i]);
    case (kind)
      FK_GOOD: begin
        push_byte(fa);
        push_byte(fb);
      end
      FK_BAD_A: begin
        bad = pick_bad(fa);
        push_byte(bad);
        if (bad == cur_sync[7:0]) build_frame(FK_GOOD, pick_len(FK_GOOD), 1'b0);
      end
      FK_BAD_B: begin
        push_byte(fa);
        bad = pick_bad(fb);
        push_byte(bad);
        if (bad == cur_sync[7:0]) build_frame(FK_GOOD, pick_len(FK_GOOD), 1'b0);
      end
      FK_CUT: begin
        if (cur_tmo <= 40) repeat (cur_tmo + 1) push_raw(REQ_TICK, 8'($urandom));
      end
      default: ;
    endcase
  endtask

  task automatic send_stream();
    req_item_t it;
    int        gap;
    while (byte_stream_q.size() != 0) begin
      it = byte_stream_q.pop_front();
      if (burst_left == 0) begin
        burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
                                                 : $urandom_range(1, 25);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        if (gap != 0) begin
          req_ch.valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      burst_left--;
      req_ch.valid     <= 1'b1;
      req_ch.req_type  <= it.rt;
      req_ch.data_byte <= it.d;
      do @(posedge clk); while (req_ch.ready !== 1'b1);
      sent++;
    end
    req_ch.valid <= 1'b0;
  endtask

  task automatic wait_idle();
    while (n_res != sent) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apply_config(logic [7:0] s, logic [10:0] m, logic [15:0] t);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_SYNC_BYTE;
    cfg_data  <= {8'($urandom), s};
    @(posedge clk);
    cfg_index <= CFG_MAX_LENGTH;
    cfg_data  <= {5'($urandom), m};
    @(posedge clk);
    cfg_index <= CFG_TIMEOUT_TICKS;
    cfg_data  <= t;
    @(posedge clk);
    cfg_we    <= 1'b0;
    cur_sync = s;
    cur_max  = m;
    cur_tmo  = t;
    n_settings++;
  endtask

  task automatic run_phase(logic [7:0] s, logic [10:0] m, logic [15:0] t, int tick_rate,
                           int frames);
    int          r;
    frame_kind_t kind;
    apply_config(s, m, t);
    tick_pct = tick_rate;
    for (int f = 0; f < frames; f++) begin
      r = $urandom_range(0, 99);
      kind = (r < 58) ? FK_GOOD : (r < 68) ? FK_BAD_A : (r < 76) ? FK_BAD_B :
             (r < 84) ? FK_TOO_LONG : (r < 93) ? FK_CUT : FK_NOISE;
      if (kind == FK_NOISE) begin
        repeat ($urandom_range(1, 4))
          push_raw(($urandom_range(0, 2) == 0) ? REQ_TICK : REQ_BYTE, 8'($urandom));
      end else begin
        build_frame(kind, pick_len(kind), 1'b1);
      end
      // let the block drain completely midway through each phase
      if (f == frames / 2) begin
        send_stream();
        wait_idle();
      end
    end
    send_stream();
    wait_idle();
  endtask

  initial begin : rx_side
    int mode, span;
    res_ch.ready = 1'b0;
    forever begin
      if (rx_holds_wanted > rx_holds_done) begin
        rx_holds_done++;
        @(posedge clk);
        res_ch.ready <= 1'b0;
        repeat (400) @(posedge clk);
      end
      mode = $urandom_range(0, 3);
      span = $urandom_range(10, 120);
      repeat (span) begin
        @(posedge clk);
        case (mode)
          0: res_ch.ready <= 1'b1;
          1: res_ch.ready <= 1'($urandom_range(0, 1));
          2: res_ch.ready <= ($urandom_range(0, 3) == 0);
          default: res_ch.ready <= ~res_ch.ready;
        endcase
      end
    end
  end

  initial begin : watchdog
    cycle_cnt = 0;
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("FAILURE");
    $finish;
  end

  initial begin : stim
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_index        = CFG_SYNC_BYTE;
    cfg_data         = '0;
    req_ch.valid     = 1'b0;
    req_ch.req_type  = REQ_BYTE;
    req_ch.data_byte = '0;
    sent             = 0;
    burst_left       = 0;
    tick_pct         = 0;
    frame_items      = 0;
    n_settings       = 1;
    rx_holds_wanted  = 0;
    rx_holds_done    = 0;
    cur_sync         = SyncByteRst;
    cur_max          = MaxLengthRst;
    cur_tmo          = TimeoutTicksRst;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: stray byte, idle tick, short, empty, oversized, bad check
    push_raw(REQ_BYTE, 8'h00);
    push_raw(REQ_TICK, 8'hFF);
    build_frame(FK_GOOD, 2, 1'b1);
    build_frame(FK_GOOD, 0, 1'b1);
    build_frame(FK_TOO_LONG, 65535, 1'b1);
    build_frame(FK_BAD_A, 0, 1'b1);
    send_stream();
    wait_idle();

    // full-size payload; length register above the payload limit
    apply_config(8'($urandom), 11'h7FF, 16'hFFFF);
    tick_pct = 0;
    build_frame(FK_GOOD, MaxPayload, 1'b1);
    build_frame(FK_TOO_LONG, MaxPayload + 1, 1'b1);
    send_stream();
    wait_idle();

    rx_holds_wanted = 1;
    run_phase(8'h00, 11'd1024, 16'd0, 25, 4);
    run_phase(8'hFF, 11'd0, 16'd1, 15, 4);
    run_phase(8'($urandom), 11'd1, 16'd2, 20, 4);
    run_phase(8'($urandom), 11'($urandom_range(1, 1024)), 16'($urandom_range(3, 12)), 15, 4);
    while (frame_items < ItemGoal) begin
      run_phase(8'($urandom),
                ($urandom_range(0, 3) == 0) ? 11'($urandom_range(0, 8))
                                            : 11'($urandom_range(9, 1024)),
                ($urandom_range(0, 1) == 0) ? 16'($urandom_range(2, 20))
                                            : 16'($urandom_range(1000, 65535)),
                $urandom_range(0, 20), 15);
    end

    $display("Run covered %0d requests and %0d results over %0d register settings.",
             n_req, n_res, n_settings);
    $display("%0d frames passed the Fletcher check, %0d were dropped by check, length or timeout.",
             n_good, n_dropped);
    if (mismatches == 0 && backlog == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
